>>> src/modem_reply_line_matcher_assert.svh
// ----------------------------------------------------------------------------
// Modem reply line matcher assertion macros
// Concurrent assertion wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef MODEM_REPLY_LINE_MATCHER_ASSERT_SVH
`define MODEM_REPLY_LINE_MATCHER_ASSERT_SVH

// same-cycle implication, off while in reset
`define MRLM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("modem_reply_line_matcher: assertion failed");

// next-cycle implication, off while in reset
`define MRLM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("modem_reply_line_matcher: assertion failed");

// next-cycle implication, active through reset
`define MRLM_ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("modem_reply_line_matcher: assertion failed");

`endif

>>> src/mrlm_pkg.sv
// ----------------------------------------------------------------------------
// Modem reply line matcher package
// Command codes, register indexes, character codes and shared types.
// ----------------------------------------------------------------------------
package mrlm_pkg;

    localparam int CFG_DATA_W   = 64;
    localparam int CFG_INDEX_W  = 3;
    localparam int PAT_LEN_W    = 6;
    localparam int TIMEOUT_W    = 16;
    localparam int PAT_REGS     = 6;
    localparam int PAT_REG_W    = $clog2(PAT_REGS);
    localparam int PAT_IDX_W    = 6;
    localparam int CMD_W        = 2;
    localparam int BYTE_W       = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_START = 2'd0,
        CMD_BYTE  = 2'd1,
        CMD_TICK  = 2'd2
    } t_cmd;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PATTERN_LENGTH = 3'd0,
        CFG_TIMEOUT_TICKS  = 3'd1,
        CFG_PATTERN_0      = 3'd2,
        CFG_PATTERN_1      = 3'd3,
        CFG_PATTERN_2      = 3'd4,
        CFG_PATTERN_3      = 3'd5,
        CFG_PATTERN_4      = 3'd6,
        CFG_PATTERN_5      = 3'd7
    } t_cfg_index;

    localparam logic [BYTE_W-1:0]    NEWLINE_CODE = 8'h0A;
    localparam logic [BYTE_W-1:0]    SPACE_CODE   = 8'h20;
    localparam logic [TIMEOUT_W-1:0] TICK_MAX     = 16'hFFFF;

    localparam logic OUTCOME_MATCHED   = 1'b0;
    localparam logic OUTCOME_TIMED_OUT = 1'b1;

    typedef struct packed {
        logic [PAT_LEN_W-1:0] eff_len;
        logic [TIMEOUT_W-1:0] timeout;
        logic [BYTE_W-1:0]    pat_char;
    } t_cfg_view;

    typedef struct packed {
        logic valid;
        logic outcome;
    } t_result;

endpackage

>>> src/mrlm_cfg_regs.sv
// ----------------------------------------------------------------------------
// Modem reply line matcher configuration registers
// Holds pattern length, timeout and pattern bytes; selects one pattern char.
// ----------------------------------------------------------------------------
module mrlm_cfg_regs #(
    parameter int MAX_PATTERN = 48
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_cfg_we,
    input  logic [mrlm_pkg::CFG_INDEX_W-1:0]          i_cfg_index,
    input  logic [mrlm_pkg::CFG_DATA_W-1:0]           i_cfg_data,
    input  logic [mrlm_pkg::PAT_IDX_W-1:0]            i_pat_idx,
    output mrlm_pkg::t_cfg_view                       o_view
);
    import mrlm_pkg::*;

    logic [PAT_LEN_W-1:0]  r_pat_len;
    logic [TIMEOUT_W-1:0]  r_timeout;
    logic [CFG_DATA_W-1:0] r_pattern [PAT_REGS];
    logic [CFG_DATA_W-1:0] sel_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_len <= '0;
            r_timeout <= '0;
            for (int k = 0; k < PAT_REGS; k++) begin
                r_pattern[k] <= '0;
            end
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_PATTERN_LENGTH: r_pat_len <= i_cfg_data[PAT_LEN_W-1:0];
                CFG_TIMEOUT_TICKS:  r_timeout <= i_cfg_data[TIMEOUT_W-1:0];
                default: begin
                    r_pattern[PAT_REG_W'(i_cfg_index - CFG_PATTERN_0)] <= i_cfg_data;
                end
            endcase
        end
    end

    always_comb begin
        case (i_pat_idx[PAT_IDX_W-1:3])
            3'd0:    sel_word = r_pattern[0];
            3'd1:    sel_word = r_pattern[1];
            3'd2:    sel_word = r_pattern[2];
            3'd3:    sel_word = r_pattern[3];
            3'd4:    sel_word = r_pattern[4];
            3'd5:    sel_word = r_pattern[5];
            default: sel_word = '0;
        endcase
    end

    always_comb begin
        o_view.eff_len  = (r_pat_len > PAT_LEN_W'(MAX_PATTERN)) ? PAT_LEN_W'(MAX_PATTERN)
                                                                : r_pat_len;
        o_view.timeout  = r_timeout;
        o_view.pat_char = sel_word[{i_pat_idx[2:0], 3'b000} +: BYTE_W];
    end

endmodule

>>> src/mrlm_core.sv
// ----------------------------------------------------------------------------
// Modem reply line matcher core
// Arm state, line position, on-the-fly prefix compare and tick timeout.
// ----------------------------------------------------------------------------
module mrlm_core #(
    parameter int LINE_CAPACITY = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_fire,
    input  logic [mrlm_pkg::CMD_W-1:0]           i_cmd,
    input  logic [mrlm_pkg::BYTE_W-1:0]          i_rx_byte,
    input  mrlm_pkg::t_cfg_view                  i_view,
    output logic [mrlm_pkg::PAT_IDX_W-1:0]       o_pat_idx,
    output mrlm_pkg::t_result                    o_result
);
    import mrlm_pkg::*;

    localparam int POS_W = $clog2(LINE_CAPACITY + 1);

    logic                 r_armed,  n_armed;
    logic [POS_W-1:0]     r_pos,    n_pos;
    logic                 r_eq,     n_eq;
    logic [TIMEOUT_W-1:0] r_ticks,  n_ticks;
    logic [TIMEOUT_W-1:0] ticks_inc;

    assign o_pat_idx = r_pos[PAT_IDX_W-1:0];
    assign ticks_inc = (r_ticks != TICK_MAX) ? r_ticks + 1'b1 : r_ticks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
            r_pos   <= '0;
            r_eq    <= 1'b1;
            r_ticks <= '0;
        end else begin
            r_armed <= n_armed;
            r_pos   <= n_pos;
            r_eq    <= n_eq;
            r_ticks <= n_ticks;
        end
    end

    always_comb begin
        n_armed          = r_armed;
        n_pos            = r_pos;
        n_eq             = r_eq;
        n_ticks          = r_ticks;
        o_result.valid   = 1'b0;
        o_result.outcome = OUTCOME_MATCHED;
        if (i_fire) begin
            case (t_cmd'(i_cmd))
                CMD_START: begin
                    n_armed = 1'b1;
                    n_pos   = '0;
                    n_eq    = 1'b1;
                    n_ticks = '0;
                end
                CMD_BYTE: begin
                    if (r_armed) begin
                        if (i_rx_byte == NEWLINE_CODE) begin
                            if (r_pos != '0) begin
                                if (r_eq && (r_pos >= POS_W'(i_view.eff_len))) begin
                                    n_armed          = 1'b0;
                                    o_result.valid   = 1'b1;
                                    o_result.outcome = OUTCOME_MATCHED;
                                end
                                n_pos = '0;
                                n_eq  = 1'b1;
                            end
                        end else if ((i_rx_byte >= SPACE_CODE)
                                     && (r_pos < POS_W'(LINE_CAPACITY))) begin
                            if ((r_pos < POS_W'(i_view.eff_len))
                                && (i_rx_byte != i_view.pat_char)) begin
                                n_eq = 1'b0;
                            end
                            n_pos = r_pos + 1'b1;
                        end
                    end
                end
                CMD_TICK: begin
                    if (r_armed && (i_view.timeout != '0)) begin
                        n_ticks = ticks_inc;
                        if (ticks_inc >= i_view.timeout) begin
                            n_armed          = 1'b0;
                            n_pos            = '0;
                            n_eq             = 1'b1;
                            o_result.valid   = 1'b1;
                            o_result.outcome = OUTCOME_TIMED_OUT;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

>>> src/modem_reply_line_matcher.sv
// ----------------------------------------------------------------------------
// Modem reply line matcher
// Watches modem bytes for a reply line starting with a configured pattern,
// with an optional tick timeout.
//
//   channel  direction  handshake                   payload
//   in       to block   i_in_valid / o_in_stall     i_cmd, i_rx_byte
//   out      from block o_out_valid / i_out_stall   o_outcome
//   cfg      to block   i_cfg_we                    i_cfg_index, i_cfg_data
//
// One item per cycle sustained while the output is not stalled; an item's
// result passes through the input register, then the result register.
// Reset is synchronous and clears arm state, counters and both registers.
// The input register holds one item while the result register is stalled;
// o_in_stall rises only when both are full and the output is stalled.
// ----------------------------------------------------------------------------
module modem_reply_line_matcher #(
    parameter int LINE_CAPACITY = 256,
    parameter int MAX_PATTERN   = 48
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [mrlm_pkg::CMD_W-1:0]           i_cmd,
    input  logic [mrlm_pkg::BYTE_W-1:0]          i_rx_byte,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_outcome,
    input  logic                                 i_cfg_we,
    input  logic [mrlm_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [mrlm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import mrlm_pkg::*;

    logic              r_in_valid;
    logic [CMD_W-1:0]  r_cmd;
    logic [BYTE_W-1:0] r_byte;
    logic              r_out_valid;
    logic              r_outcome;
    logic              advance;
    logic              fire;
    logic              in_xfer;
    logic [PAT_IDX_W-1:0] pat_idx;
    t_cfg_view         view;
    t_result           result;

    assign advance     = !r_out_valid || !i_out_stall;
    assign fire        = r_in_valid && advance;
    assign o_in_stall  = r_in_valid && !advance;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_outcome   = r_outcome;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= result.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cmd  <= i_cmd;
            r_byte <= i_rx_byte;
        end
        if (result.valid) begin
            r_outcome <= result.outcome;
        end
    end

    mrlm_cfg_regs #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pat_idx   (pat_idx),
        .o_view      (view)
    );

    mrlm_core #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_cmd     (r_cmd),
        .i_rx_byte (r_byte),
        .i_view    (view),
        .o_pat_idx (pat_idx),
        .o_result  (result)
    );

endmodule

>>> src/mrlm_checker.sv
// ----------------------------------------------------------------------------
// Modem reply line matcher checker
// Port-level assertions on handshake and reset behavior, bound to the top.
// ----------------------------------------------------------------------------
`include "modem_reply_line_matcher_assert.svh"

module mrlm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_outcome
);

    `MRLM_ASSERT_NEXT(a_out_valid_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `MRLM_ASSERT_NEXT(a_outcome_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_outcome))
    `MRLM_ASSERT_IMPL(a_stall_only_blocked, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)
    `MRLM_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n, !o_out_valid && !o_in_stall)

endmodule

bind modem_reply_line_matcher mrlm_checker u_mrlm_checker (.*);
